// ===== hdl/arpi_pkg.sv =====
// Package: shared types, codes, widths and reset values for the relay pulse interlock.
package arpi_pkg;

   localparam int PULSE_W    = 16;
   localparam int COOL_W     = 16;
   localparam int DEBOUNCE_W = 8;
   localparam int ELAPSED_W  = 17;
   localparam int SINCE_W    = 16;
   localparam int COUNT_W    = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [PULSE_W-1:0]    PULSE_RESET    = PULSE_W'(1000);
   localparam logic [COOL_W-1:0]     COOL_RESET     = COOL_W'(5000);
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_TRIGGER = 2'd1,
      MODE_ARM     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      TRIG_NONE     = 2'd0,
      TRIG_ACCEPTED = 2'd1,
      TRIG_DISARMED = 2'd2,
      TRIG_COOLDOWN = 2'd3
   } trig_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_TICKS    = 2'd0,
      CSR_COOLDOWN_TICKS = 2'd1,
      CSR_DEBOUNCE_TICKS = 2'd2,
      CSR_ACTIVE_LOW     = 2'd3
   } csr_index_type;

endpackage

// ===== hdl/arpi_req_if.sv =====
// Interface: event channel into the interlock.
interface arpi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       button_level;
   logic       arm_value;

   modport source (output valid, output mode, output button_level, output arm_value,
                   input ready);
   modport sink   (input valid, input mode, input button_level, input arm_value,
                   output ready);
endinterface

// ===== hdl/arpi_rsp_if.sv =====
// Interface: status channel out of the interlock.
interface arpi_rsp_if;
   logic        valid;
   logic        ready;
   logic        relay_drive;
   logic        relay_on;
   logic        armed_now;
   logic        armed_report;
   logic [1:0]  trigger_status;
   logic [31:0] accepted_count;

   modport source (output valid, output relay_drive, output relay_on, output armed_now,
                   output armed_report, output trigger_status, output accepted_count,
                   input ready);
   modport sink   (input valid, input relay_drive, input relay_on, input armed_now,
                   input armed_report, input trigger_status, input accepted_count,
                   output ready);
endinterface

// ===== hdl/armed_relay_pulse_interlock.sv =====
// Top level: armed relay pulse interlock, event decode, state update and result register.
//
// Takes one event word per clock (tick with button level, trigger, remote arm) and returns
// one status word per event from a single result register, valid in the cycle after
// acceptance. All state updates are short flag logic, saturating timers and a wrapping
// accepted count, done at the accepting edge, so the sustained rate is one event per
// cycle; req ready is low only while a result sits unclaimed and rsp ready is low. Config
// writes take effect on the next event and are expected only while the block is idle.
module armed_relay_pulse_interlock (
   input  logic                                clock,
   input  logic                                reset,
   arpi_req_if.sink                            req_if,
   arpi_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [arpi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpi_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import arpi_pkg::*;

   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX = '1;
   localparam logic [SINCE_W-1:0]    SINCE_MAX   = '1;
   localparam logic [DEBOUNCE_W-1:0] SAMPLE_MAX  = '1;

   logic [PULSE_W-1:0]    pulse_ticks_ff;
   logic [COOL_W-1:0]     cooldown_ticks_ff;
   logic [DEBOUNCE_W-1:0] debounce_ticks_ff;
   logic                  active_low_ff;

   logic                  armed_ff, armed_in;
   logic                  pulse_ff, pulse_in;
   logic                  prev_button_ff, prev_button_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [SINCE_W-1:0]    since_ff, since_in;
   logic [DEBOUNCE_W-1:0] sample_ff, sample_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic                  report_in;
   trig_status_type       status_in;

   logic                  rsp_valid_ff;
   logic                  relay_drive_ff, relay_on_ff, armed_now_ff, armed_report_ff;
   trig_status_type       status_ff;
   logic [COUNT_W-1:0]    count_ff;

   logic                  accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      armed_in       = armed_ff;
      pulse_in       = pulse_ff;
      prev_button_in = prev_button_ff;
      elapsed_in     = elapsed_ff;
      since_in       = since_ff;
      sample_in      = sample_ff;
      total_in       = total_ff;
      report_in      = 1'b0;
      status_in      = TRIG_NONE;
      case (mode_type'(req_if.mode))
         MODE_TICK: begin
            elapsed_in = (elapsed_ff == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ff + 1'b1;
            since_in   = (since_ff == SINCE_MAX) ? SINCE_MAX : since_ff + 1'b1;
            sample_in  = (sample_ff == SAMPLE_MAX) ? SAMPLE_MAX : sample_ff + 1'b1;
            if (sample_in >= debounce_ticks_ff) begin
               sample_in = '0;
               if (!req_if.button_level && prev_button_ff) begin
                  armed_in  = !armed_ff;
                  report_in = 1'b1;
                  if (armed_ff) pulse_in = 1'b0;
               end
               prev_button_in = req_if.button_level;
            end
            if (pulse_in && (elapsed_in > {1'b0, pulse_ticks_ff})) pulse_in = 1'b0;
         end
         MODE_TRIGGER: begin
            if (!armed_ff) begin
               status_in = TRIG_DISARMED;
            end else if (since_ff < cooldown_ticks_ff) begin
               status_in = TRIG_COOLDOWN;
            end else begin
               status_in  = TRIG_ACCEPTED;
               since_in   = '0;
               total_in   = total_ff + 1'b1;
               pulse_in   = 1'b1;
               elapsed_in = '0;
            end
         end
         MODE_ARM: begin
            armed_in  = req_if.arm_value;
            report_in = 1'b1;
            if (!req_if.arm_value) pulse_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff    <= PULSE_RESET;
         cooldown_ticks_ff <= COOL_RESET;
         debounce_ticks_ff <= DEBOUNCE_RESET;
         active_low_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSE_TICKS:    pulse_ticks_ff    <= csr_wdata[PULSE_W-1:0];
            CSR_COOLDOWN_TICKS: cooldown_ticks_ff <= csr_wdata[COOL_W-1:0];
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_ACTIVE_LOW:     active_low_ff     <= csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         pulse_ff       <= 1'b0;
         prev_button_ff <= 1'b1;
         elapsed_ff     <= '0;
         since_ff       <= '0;
         sample_ff      <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            armed_ff       <= armed_in;
            pulse_ff       <= pulse_in;
            prev_button_ff <= prev_button_in;
            elapsed_ff     <= elapsed_in;
            since_ff       <= since_in;
            sample_ff      <= sample_in;
            total_ff       <= total_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         relay_drive_ff  <= pulse_in ^ active_low_ff;
         relay_on_ff     <= pulse_in;
         armed_now_ff    <= armed_in;
         armed_report_ff <= report_in;
         status_ff       <= status_in;
         count_ff        <= total_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.relay_drive    = relay_drive_ff;
   assign rsp_if.relay_on       = relay_on_ff;
   assign rsp_if.armed_now      = armed_now_ff;
   assign rsp_if.armed_report   = armed_report_ff;
   assign rsp_if.trigger_status = status_ff;
   assign rsp_if.accepted_count = count_ff;

endmodule
